[design/nat64_pkg.sv]
package nat64_pkg;

  localparam int unsigned Entries = 32;
  localparam int unsigned PortFirst = 10000;
  localparam int unsigned PortLimit = 20000;
  localparam int unsigned PortSpan = PortLimit - PortFirst;
  localparam logic [15:0] LfsrTaps = 16'hB400;

  typedef enum logic [2:0] {
    REQ_TICK        = 3'd0,
    REQ_LOOKUP_OUT  = 3'd1,
    REQ_LOOKUP_IN   = 3'd2,
    REQ_CREATE      = 3'd3,
    REQ_SET_LIFE    = 3'd4,
    REQ_SET_RECYCLE = 3'd5
  } req_type_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_SLOT,
    S_APPLY,
    S_PORT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic        valid;
    logic [63:0] ip6_hi;
    logic [63:0] ip6_lo;
    logic [31:0] ip4_addr;
    logic [15:0] ip6_port;
    logic [15:0] ip4_port;
    logic [15:0] mapped;
    logic [7:0]  protocol;
    logic        recyclable;
    logic [31:0] remaining;
    logic [31:0] stamp;
    logic [31:0] cnt_6to4;
    logic [31:0] cnt_4to6;
  } entry_t;

  typedef struct packed {
    logic        shift;
    logic        tick;
    logic        drop;
    logic        wr;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] ip6_addr_hi;
    logic [63:0] ip6_addr_lo;
    logic [15:0] ip6_port_in;
    logic [31:0] ip4_addr_in;
    logic [15:0] ip4_port_in;
    logic [7:0]  protocol_in;
    logic [15:0] xlat_port_key;
    logic [4:0]  entry_select;
    logic [31:0] lifetime_ticks;
  } req_t;

endpackage

[design/nat64_req_if.sv]
interface nat64_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [63:0] ip6_addr_hi;
  logic [63:0] ip6_addr_lo;
  logic [15:0] ip6_port_in;
  logic [31:0] ip4_addr_in;
  logic [15:0] ip4_port_in;
  logic [7:0]  protocol_in;
  logic [15:0] xlat_port_key;
  logic [4:0]  entry_select;
  logic [31:0] lifetime_ticks;

  modport source (
    output valid, req_type, ip6_addr_hi, ip6_addr_lo, ip6_port_in, ip4_addr_in,
           ip4_port_in, protocol_in, xlat_port_key, entry_select, lifetime_ticks,
    input  ready
  );
  modport sink (
    input  valid, req_type, ip6_addr_hi, ip6_addr_lo, ip6_port_in, ip4_addr_in,
           ip4_port_in, protocol_in, xlat_port_key, entry_select, lifetime_ticks,
    output ready
  );
endinterface

[design/nat64_res_if.sv]
interface nat64_res_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [4:0]  entry_index;
  logic [15:0] xlat_port;
  logic [63:0] out_ip6_hi;
  logic [63:0] out_ip6_lo;
  logic [15:0] out_ip6_port;
  logic [31:0] out_ip4_addr;
  logic [15:0] out_ip4_port;
  logic [31:0] count_6to4;
  logic [31:0] count_4to6;

  modport source (
    output valid, found, entry_index, xlat_port, out_ip6_hi, out_ip6_lo,
           out_ip6_port, out_ip4_addr, out_ip4_port, count_6to4, count_4to6,
    input  ready
  );
  modport sink (
    input  valid, found, entry_index, xlat_port, out_ip6_hi, out_ip6_lo,
           out_ip6_port, out_ip4_addr, out_ip4_port, count_6to4, count_4to6,
    output ready
  );
endinterface

[design/nat64_cell.sv]
module nat64_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nat64_pkg::cell_ctrl_t ctrl_i,
  input  nat64_pkg::entry_t    shift_i,
  input  nat64_pkg::entry_t    wr_i,
  output nat64_pkg::entry_t    entry_o
);

  logic              valid_q, valid_d;
  nat64_pkg::entry_t data_q, data_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (ctrl_i.wr) begin
      data_d  = wr_i;
      valid_d = wr_i.valid;
    end else if (ctrl_i.shift) begin
      data_d  = shift_i;
      valid_d = shift_i.valid;
    end else begin
      if (ctrl_i.tick && valid_q && (data_q.remaining != 32'd0)) begin
        data_d.remaining = data_q.remaining - 32'd1;
      end
      if (ctrl_i.drop && valid_q && (data_q.remaining == 32'd0)) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_comb begin
    entry_o       = data_q;
    entry_o.valid = valid_q;
  end

endmodule

[design/nat64_port_gen.sv]
module nat64_port_gen (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        step_i,
  output logic [15:0] port_o
);

  localparam int unsigned MaxMult = 65535 / nat64_pkg::PortSpan;

  logic [15:0] lfsr_q, lfsr_d;
  logic [15:0] port_q, port_d;
  logic [15:0] shifted;
  logic [15:0] residue;

  always_comb begin
    shifted = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? nat64_pkg::LfsrTaps : 16'd0);
    residue = shifted;
    for (int k = 1; k <= int'(MaxMult); k++) begin
      if (shifted >= 16'(k * int'(nat64_pkg::PortSpan))) begin
        residue = shifted - 16'(k * int'(nat64_pkg::PortSpan));
      end
    end
  end

  always_comb begin
    lfsr_d = lfsr_q;
    port_d = port_q;
    if (cfg_we_i) begin
      lfsr_d = (cfg_wdata_i == 16'd0) ? 16'd1 : cfg_wdata_i;
    end else if (step_i) begin
      lfsr_d = shifted;
      port_d = 16'(nat64_pkg::PortFirst) + residue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= 16'd1;
      port_q <= 16'(nat64_pkg::PortFirst);
    end else begin
      lfsr_q <= lfsr_d;
      port_q <= port_d;
    end
  end

  assign port_o = port_q;

endmodule

[design/nat64_address_map_table_unit.sv]
// A tick or an unused request type passes through PREP and OUT before its result beat.
// Lookups and set requests pass PREP, one full SCAN turn of the entry ring, APPLY and OUT.
// Creates run PREP, SCAN, SLOT, PORT (retried per collision) and OUT; failed ones skip PORT.
// One request is in work at a time; the next is accepted once the result is registered.
// Reset clears all valid bits at once, loads the LFSR with 1, the next port with 10000,
// and the creation counter with 0; there is no clearing pass.
module nat64_address_map_table_unit #(
  parameter int unsigned ENTRIES = nat64_pkg::Entries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  nat64_req_if.sink   req_i,
  nat64_res_if.source res_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);

  nat64_pkg::state_e     state_q, state_d;
  nat64_pkg::req_t       rq_q;
  nat64_pkg::entry_t     ring [ENTRIES];
  nat64_pkg::entry_t     head, wr_data, best_q, res_q;
  nat64_pkg::cell_ctrl_t base_ctrl;
  logic [ENTRIES-1:0]    clash_vec;
  logic                  clash, wr_en, port_step;
  logic [15:0]           next_port;
  logic [IdxW-1:0]       scan_idx_q, best_idx_q, free_idx_q, res_idx_q, sel_idx;
  logic                  best_found_q, free_found_q, res_found_q, res_valid_q;
  logic [31:0]           best_age_q, cc_q, head_age;
  logic                  scan_last, sel_ok, out_hit, in_hit, vic_take, sel_hit, take;
  logic                  accept;

  assign accept = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == nat64_pkg::S_IDLE);

  nat64_port_gen u_port_gen (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .step_i (port_step),
    .port_o (next_port)
  );

  for (genvar p = 0; p < ENTRIES; p++) begin : g_cell
    localparam int unsigned Nbr = (p + 1) % ENTRIES;
    nat64_pkg::cell_ctrl_t ctrl;
    always_comb begin
      ctrl    = base_ctrl;
      ctrl.wr = wr_en && (best_idx_q == IdxW'(p));
    end
    nat64_cell u_cell (
      .clk_i,
      .rst_ni,
      .ctrl_i  (ctrl),
      .shift_i (ring[Nbr]),
      .wr_i    (wr_data),
      .entry_o (ring[p])
    );
    assign clash_vec[p] = ring[p].valid && (ring[p].mapped == next_port) &&
                          (best_idx_q != IdxW'(p));
  end

  assign clash = |clash_vec;

  assign head      = ring[0];
  assign head_age  = cc_q - head.stamp;
  assign scan_last = (scan_idx_q == IdxW'(ENTRIES - 1));
  assign sel_ok    = 32'(rq_q.entry_select) < 32'(ENTRIES);
  assign sel_idx   = IdxW'(rq_q.entry_select);

  assign out_hit = head.valid && (head.protocol == rq_q.protocol_in) &&
                   (head.ip4_port == rq_q.ip4_port_in) &&
                   (head.ip6_port == rq_q.ip6_port_in) &&
                   (head.ip4_addr == rq_q.ip4_addr_in) &&
                   (head.ip6_hi == rq_q.ip6_addr_hi) && (head.ip6_lo == rq_q.ip6_addr_lo);
  assign in_hit  = head.valid && (head.mapped == rq_q.xlat_port_key) &&
                   (head.protocol == rq_q.protocol_in);
  assign vic_take = head.valid && head.recyclable &&
                    (!best_found_q || (head.remaining < best_q.remaining) ||
                     ((head.remaining == best_q.remaining) && (head_age > best_age_q)));
  assign sel_hit = sel_ok && (scan_idx_q == sel_idx) && head.valid;

  always_comb begin
    case (rq_q.req_type)
      nat64_pkg::REQ_LOOKUP_OUT:  take = out_hit && (!best_found_q || head_age > best_age_q);
      nat64_pkg::REQ_LOOKUP_IN:   take = in_hit && (!best_found_q || head_age > best_age_q);
      nat64_pkg::REQ_CREATE:      take = vic_take;
      nat64_pkg::REQ_SET_LIFE:    take = sel_hit;
      nat64_pkg::REQ_SET_RECYCLE: take = sel_hit;
      default:                    take = 1'b0;
    endcase
  end

  always_comb begin
    wr_data = best_q;
    if (state_q == nat64_pkg::S_PORT) begin
      wr_data.valid      = 1'b1;
      wr_data.ip6_hi     = rq_q.ip6_addr_hi;
      wr_data.ip6_lo     = rq_q.ip6_addr_lo;
      wr_data.ip4_addr   = rq_q.ip4_addr_in;
      wr_data.ip6_port   = rq_q.ip6_port_in;
      wr_data.ip4_port   = rq_q.ip4_port_in;
      wr_data.mapped     = next_port;
      wr_data.protocol   = rq_q.protocol_in;
      wr_data.recyclable = 1'b0;
      wr_data.remaining  = 32'd0;
      wr_data.stamp      = cc_q;
      wr_data.cnt_6to4   = 32'd1;
      wr_data.cnt_4to6   = 32'd0;
    end else begin
      case (rq_q.req_type)
        nat64_pkg::REQ_LOOKUP_OUT:  wr_data.cnt_6to4 = best_q.cnt_6to4 + 32'd1;
        nat64_pkg::REQ_LOOKUP_IN:   wr_data.cnt_4to6 = best_q.cnt_4to6 + 32'd1;
        nat64_pkg::REQ_SET_LIFE:    wr_data.remaining = rq_q.lifetime_ticks;
        nat64_pkg::REQ_SET_RECYCLE: wr_data.recyclable = 1'b1;
        default:                    wr_data = best_q;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      nat64_pkg::S_IDLE: begin
        if (accept) state_d = nat64_pkg::S_PREP;
      end
      nat64_pkg::S_PREP: begin
        case (rq_q.req_type)
          nat64_pkg::REQ_LOOKUP_OUT,
          nat64_pkg::REQ_LOOKUP_IN,
          nat64_pkg::REQ_CREATE,
          nat64_pkg::REQ_SET_LIFE,
          nat64_pkg::REQ_SET_RECYCLE: state_d = nat64_pkg::S_SCAN;
          default:                    state_d = nat64_pkg::S_OUT;
        endcase
      end
      nat64_pkg::S_SCAN: begin
        if (scan_last) begin
          state_d = (rq_q.req_type == nat64_pkg::REQ_CREATE) ? nat64_pkg::S_SLOT
                                                              : nat64_pkg::S_APPLY;
        end
      end
      nat64_pkg::S_SLOT: begin
        state_d = (free_found_q || best_found_q) ? nat64_pkg::S_PORT : nat64_pkg::S_OUT;
      end
      nat64_pkg::S_APPLY: state_d = nat64_pkg::S_OUT;
      nat64_pkg::S_PORT: begin
        if (!clash) state_d = nat64_pkg::S_OUT;
      end
      nat64_pkg::S_OUT: begin
        if (!res_valid_q || res_o.ready) state_d = nat64_pkg::S_IDLE;
      end
      default: state_d = nat64_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    base_ctrl = '0;
    wr_en     = 1'b0;
    port_step = 1'b0;
    case (state_q)
      nat64_pkg::S_PREP: begin
        base_ctrl.tick = (rq_q.req_type == nat64_pkg::REQ_TICK);
        base_ctrl.drop = (rq_q.req_type == nat64_pkg::REQ_LOOKUP_OUT) ||
                         (rq_q.req_type == nat64_pkg::REQ_LOOKUP_IN) ||
                         (rq_q.req_type == nat64_pkg::REQ_CREATE);
      end
      nat64_pkg::S_SCAN:  base_ctrl.shift = 1'b1;
      nat64_pkg::S_APPLY: wr_en = best_found_q;
      nat64_pkg::S_PORT: begin
        port_step = 1'b1;
        wr_en     = !clash;
      end
      default: begin
        base_ctrl = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= nat64_pkg::S_IDLE;
      scan_idx_q   <= '0;
      best_found_q <= 1'b0;
      free_found_q <= 1'b0;
      res_valid_q  <= 1'b0;
      cc_q         <= 32'd0;
    end else begin
      state_q <= state_d;
      if ((state_q == nat64_pkg::S_OUT) && (!res_valid_q || res_o.ready)) begin
        res_valid_q <= 1'b1;
      end else if (res_valid_q && res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        nat64_pkg::S_IDLE: begin
          scan_idx_q   <= '0;
          best_found_q <= 1'b0;
          free_found_q <= 1'b0;
        end
        nat64_pkg::S_SCAN: begin
          scan_idx_q <= scan_idx_q + IdxW'(1);
          if (take) best_found_q <= 1'b1;
          if ((rq_q.req_type == nat64_pkg::REQ_CREATE) && !head.valid) begin
            free_found_q <= 1'b1;
          end
        end
        nat64_pkg::S_SLOT: begin
          if (free_found_q) best_found_q <= 1'b1;
        end
        nat64_pkg::S_PORT: begin
          if (!clash) cc_q <= cc_q + 32'd1;
        end
        default: begin
          cc_q <= cc_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) rq_q <= nat64_pkg::req_t'({req_i.req_type, req_i.ip6_addr_hi,
                         req_i.ip6_addr_lo, req_i.ip6_port_in, req_i.ip4_addr_in,
                         req_i.ip4_port_in, req_i.protocol_in, req_i.xlat_port_key,
                         req_i.entry_select, req_i.lifetime_ticks});
    if ((state_q == nat64_pkg::S_SCAN) && take) begin
      best_q     <= head;
      best_idx_q <= scan_idx_q;
      best_age_q <= head_age;
    end
    if ((state_q == nat64_pkg::S_SCAN) && (rq_q.req_type == nat64_pkg::REQ_CREATE) &&
        !head.valid && !free_found_q) begin
      free_idx_q <= scan_idx_q;
    end
    if ((state_q == nat64_pkg::S_SLOT) && free_found_q) best_idx_q <= free_idx_q;
    if (wr_en) best_q <= wr_data;
    if ((state_q == nat64_pkg::S_OUT) && (!res_valid_q || res_o.ready)) begin
      res_found_q <= best_found_q;
      res_q       <= best_found_q ? best_q : '0;
      res_idx_q   <= best_found_q ? best_idx_q : '0;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.found        = res_found_q;
  assign res_o.entry_index  = 5'(res_idx_q);
  assign res_o.xlat_port    = res_q.mapped;
  assign res_o.out_ip6_hi   = res_q.ip6_hi;
  assign res_o.out_ip6_lo   = res_q.ip6_lo;
  assign res_o.out_ip6_port = res_q.ip6_port;
  assign res_o.out_ip4_addr = res_q.ip4_addr;
  assign res_o.out_ip4_port = res_q.ip4_port;
  assign res_o.count_6to4   = res_q.cnt_6to4;
  assign res_o.count_4to6   = res_q.cnt_4to6;

  a_port_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_port >= 16'(nat64_pkg::PortFirst)) && (next_port < 16'(nat64_pkg::PortLimit)))
    else $error("Next mapped port left its range.");

  a_hit_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.found) |-> ((res_o.xlat_port >= 16'(nat64_pkg::PortFirst)) &&
                                      (res_o.xlat_port < 16'(nat64_pkg::PortLimit))))
    else $error("Result beat carries a mapped port outside the pool.");

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == nat64_pkg::S_SCAN) && scan_last) |=>
      ((state_q == nat64_pkg::S_SLOT) || (state_q == nat64_pkg::S_APPLY)))
    else $error("Ring scan did not end after one full turn.");

endmodule
